### hw/rtl/c_comment_stripper_line_marker_top_defines.svh
// Assertion macros used by the checker file.
`ifndef C_COMMENT_STRIPPER_LINE_MARKER_TOP_DEFINES_SVH
`define C_COMMENT_STRIPPER_LINE_MARKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCSLM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCSLM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also checks the reset itself.
`define CCSLM_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ccslm_pkg.sv
`default_nettype none

package ccslm_pkg;

   localparam int LINE_DIGITS = 7;
   localparam int BCD_W       = 4 * LINE_DIGITS;
   localparam int DIG_W       = (LINE_DIGITS > 1) ? $clog2(LINE_DIGITS) : 1;
   localparam int HEAD_LEN    = 6;
   localparam int MAX_RESULTS = HEAD_LEN + LINE_DIGITS + 1;
   localparam int EMIT_W      = $clog2(MAX_RESULTS);

   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BLOCK_STAR
   } mode_type;

   typedef enum logic [2:0] {
      JOB_NONE,
      JOB_CHAR,
      JOB_PAIR,
      JOB_MARKER,
      JOB_UNTERM
   } job_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_of_run;
      logic       unterminated_comment;
   } rsp_type;

   typedef struct packed {
      logic inc;
      logic clear;
   } cnt_ctl_type;

   typedef struct packed {
      logic [BCD_W-1:0] bcd;
      logic [DIG_W-1:0] top;
   } cnt_stat_type;

   function automatic logic [7:0] head_char(input logic [EMIT_W-1:0] idx);
      logic [7:0] ch;
      case (idx)
         EMIT_W'(0): ch = 8'h23;
         EMIT_W'(1): ch = 8'h6c;
         EMIT_W'(2): ch = 8'h69;
         EMIT_W'(3): ch = 8'h6e;
         EMIT_W'(4): ch = 8'h65;
         default:    ch = 8'h20;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ccslm_line_count.sv
`default_nettype none

module ccslm_line_count (
   input  logic                    clock,
   input  logic                    reset,
   input  ccslm_pkg::cnt_ctl_type  ctl,
   output ccslm_pkg::cnt_stat_type stat
);

   logic [ccslm_pkg::BCD_W-1:0] bcd_ff, bcd_in;
   logic [ccslm_pkg::BCD_W-1:0] bcd_inc;
   logic                        full;
   logic                        carry;
   logic [3:0]                  digit;
   logic [ccslm_pkg::DIG_W-1:0] top;

   always_comb begin
      full    = 1'b1;
      carry   = 1'b1;
      bcd_inc = bcd_ff;
      top     = '0;
      for (int i = 0; i < ccslm_pkg::LINE_DIGITS; i++) begin
         digit = bcd_ff[4*i +: 4];
         if (digit != 4'd9) begin
            full = 1'b0;
         end
         if (digit != 4'd0) begin
            top = ccslm_pkg::DIG_W'(i);
         end
         if (carry) begin
            if (digit >= 4'd9) begin
               bcd_inc[4*i +: 4] = 4'd0;
            end else begin
               bcd_inc[4*i +: 4] = digit + 4'd1;
               carry = 1'b0;
            end
         end
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      if (ctl.clear) begin
         bcd_in = '0;
      end else if (ctl.inc && !full) begin
         bcd_in = bcd_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcd_ff <= '0;
      end else begin
         bcd_ff <= bcd_in;
      end
   end

   assign stat.bcd = bcd_ff;
   assign stat.top = top;

endmodule

`default_nettype wire

### hw/rtl/c_comment_stripper_line_marker_top.sv
// Channel | Ports                          | Moves
// req     | req_valid req_ready req_data   | one source byte or end of file per transaction
// rsp     | rsp_valid rsp_ready rsp_data   | one output byte per transaction
//
// Plain bytes pass at one per cycle unless rsp stalls; a byte with no output never waits on rsp.
// A lone slash released with its follower, or by end of file, holds the input until both bytes are loaded.
// A closing block comment yields a line marker of 8 to 7 + LINE_DIGITS bytes, one per cycle
// unless rsp stalls, into the single result register; input holds until its last byte is loaded.
// Reset is synchronous and returns to normal text with a zero line count.
// A stall on rsp backs up through the held byte into req_ready.
`default_nettype none

module c_comment_stripper_line_marker_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ccslm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ccslm_pkg::rsp_type rsp_data
);

   logic                         in_valid_ff, in_valid_in;
   ccslm_pkg::req_type           in_data_ff;
   ccslm_pkg::mode_type          mode_ff, mode_in;
   logic [ccslm_pkg::EMIT_W-1:0] emit_ff, emit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ccslm_pkg::rsp_type           rsp_data_ff;

   ccslm_pkg::job_type           job;
   logic [7:0]                   job_char;
   ccslm_pkg::cnt_ctl_type       cnt_ctl;
   ccslm_pkg::cnt_stat_type      cnt_stat;

   logic                         push;
   logic                         consume;
   logic                         elem_last;
   logic                         elem_unterm;
   logic [7:0]                   elem_char;
   logic [ccslm_pkg::EMIT_W-1:0] digit_off;
   logic [ccslm_pkg::EMIT_W-1:0] digit_pos;
   logic [ccslm_pkg::EMIT_W-1:0] top_ext;
   logic [3:0]                   digit_val;

   ccslm_line_count u_line_count (
      .clock (clock),
      .reset (reset),
      .ctl   (cnt_ctl),
      .stat  (cnt_stat)
   );

   // next scan mode
   always_comb begin
      mode_in = mode_ff;
      if (consume) begin
         if (in_data_ff.end_of_file) begin
            mode_in = ccslm_pkg::MODE_NORMAL;
         end else begin
            unique case (mode_ff)
               ccslm_pkg::MODE_NORMAL: begin
                  if (in_data_ff.char_in == ccslm_pkg::CH_SLASH) begin
                     mode_in = ccslm_pkg::MODE_SLASH;
                  end
               end
               ccslm_pkg::MODE_SLASH: begin
                  if (in_data_ff.char_in == ccslm_pkg::CH_SLASH) begin
                     mode_in = ccslm_pkg::MODE_LINE;
                  end else if (in_data_ff.char_in == ccslm_pkg::CH_STAR) begin
                     mode_in = ccslm_pkg::MODE_BLOCK;
                  end else begin
                     mode_in = ccslm_pkg::MODE_NORMAL;
                  end
               end
               ccslm_pkg::MODE_LINE: begin
                  if (in_data_ff.char_in == ccslm_pkg::CH_NL) begin
                     mode_in = ccslm_pkg::MODE_NORMAL;
                  end
               end
               ccslm_pkg::MODE_BLOCK: begin
                  if (in_data_ff.char_in == ccslm_pkg::CH_STAR) begin
                     mode_in = ccslm_pkg::MODE_BLOCK_STAR;
                  end
               end
               ccslm_pkg::MODE_BLOCK_STAR: begin
                  if (in_data_ff.char_in == ccslm_pkg::CH_SLASH) begin
                     mode_in = ccslm_pkg::MODE_NORMAL;
                  end else if (in_data_ff.char_in != ccslm_pkg::CH_STAR) begin
                     mode_in = ccslm_pkg::MODE_BLOCK;
                  end
               end
               default: mode_in = ccslm_pkg::MODE_NORMAL;
            endcase
         end
      end
   end

   // output job of the held transaction
   always_comb begin
      job      = ccslm_pkg::JOB_NONE;
      job_char = in_data_ff.char_in;
      if (in_data_ff.end_of_file) begin
         unique case (mode_ff)
            ccslm_pkg::MODE_SLASH: begin
               job      = ccslm_pkg::JOB_PAIR;
               job_char = ccslm_pkg::CH_NL;
            end
            ccslm_pkg::MODE_BLOCK, ccslm_pkg::MODE_BLOCK_STAR: begin
               job = ccslm_pkg::JOB_UNTERM;
            end
            default: begin
               job      = ccslm_pkg::JOB_CHAR;
               job_char = ccslm_pkg::CH_NL;
            end
         endcase
      end else begin
         unique case (mode_ff)
            ccslm_pkg::MODE_NORMAL: begin
               if (in_data_ff.char_in != ccslm_pkg::CH_SLASH) begin
                  job = ccslm_pkg::JOB_CHAR;
               end
            end
            ccslm_pkg::MODE_SLASH: begin
               if (in_data_ff.char_in != ccslm_pkg::CH_SLASH &&
                   in_data_ff.char_in != ccslm_pkg::CH_STAR) begin
                  job = ccslm_pkg::JOB_PAIR;
               end
            end
            ccslm_pkg::MODE_BLOCK_STAR: begin
               if (in_data_ff.char_in == ccslm_pkg::CH_SLASH) begin
                  job = ccslm_pkg::JOB_MARKER;
               end
            end
            default: job = ccslm_pkg::JOB_NONE;
         endcase
      end
   end

   // byte at the current emit position
   always_comb begin
      top_ext     = ccslm_pkg::EMIT_W'(cnt_stat.top);
      digit_off   = emit_ff - ccslm_pkg::EMIT_W'(ccslm_pkg::HEAD_LEN);
      digit_pos   = top_ext - digit_off;
      digit_val   = 4'd0;
      elem_char   = job_char;
      elem_unterm = 1'b0;
      elem_last   = 1'b1;
      for (int i = 0; i < ccslm_pkg::LINE_DIGITS; i++) begin
         if (digit_pos == ccslm_pkg::EMIT_W'(i)) begin
            digit_val = cnt_stat.bcd[4*i +: 4];
         end
      end
      case (job)
         ccslm_pkg::JOB_PAIR: begin
            elem_last = (emit_ff != '0);
            if (emit_ff == '0) begin
               elem_char = ccslm_pkg::CH_SLASH;
            end
         end
         ccslm_pkg::JOB_MARKER: begin
            elem_last = (emit_ff ==
               ccslm_pkg::EMIT_W'(ccslm_pkg::HEAD_LEN + 1) + top_ext);
            if (emit_ff < ccslm_pkg::EMIT_W'(ccslm_pkg::HEAD_LEN)) begin
               elem_char = ccslm_pkg::head_char(emit_ff);
            end else if (digit_off <= top_ext) begin
               elem_char = ccslm_pkg::CH_ZERO + {4'd0, digit_val};
            end else begin
               elem_char = ccslm_pkg::CH_NL;
            end
         end
         ccslm_pkg::JOB_UNTERM: begin
            elem_char   = ccslm_pkg::CH_NUL;
            elem_unterm = 1'b1;
         end
         default: ;
      endcase
   end

   assign push      = in_valid_ff && (job != ccslm_pkg::JOB_NONE) &&
                      (!rsp_valid_ff || rsp_ready);
   assign consume   = in_valid_ff && ((job == ccslm_pkg::JOB_NONE) || (push && elem_last));
   assign req_ready = !in_valid_ff || consume;

   assign cnt_ctl.inc   = consume && !in_data_ff.end_of_file &&
                          (in_data_ff.char_in == ccslm_pkg::CH_NL);
   assign cnt_ctl.clear = consume && in_data_ff.end_of_file;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      emit_in = emit_ff;
      if (push) begin
         emit_in = elem_last ? '0 : emit_ff + ccslm_pkg::EMIT_W'(1);
      end
   end

   assign rsp_valid_in = push || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mode_ff      <= ccslm_pkg::MODE_NORMAL;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mode_ff      <= mode_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (push) begin
         rsp_data_ff.out_char             <= elem_char;
         rsp_data_ff.last_of_run          <= elem_last;
         rsp_data_ff.unterminated_comment <= elem_unterm;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### hw/rtl/ccslm_checker.sv
`default_nettype none
`include "c_comment_stripper_line_marker_top_defines.svh"

module ccslm_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire ccslm_pkg::rsp_type rsp_data
);

   `CCSLM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp transaction changed while stalled")
   `CCSLM_ASSERT_NOW(a_unterm_form, rsp_valid && rsp_data.unterminated_comment, rsp_data.last_of_run && (rsp_data.out_char == ccslm_pkg::CH_NUL), "unterminated flag on a non-final or nonzero byte")
   `CCSLM_ASSERT_NOW(a_run_blocks_req, rsp_valid && !rsp_data.last_of_run && !rsp_ready, !req_ready, "req accepted while a run is still stalled")
   `CCSLM_ASSERT_RESET(a_reset_clears, reset, !rsp_valid, "rsp valid right after reset")

endmodule

bind c_comment_stripper_line_marker_top ccslm_checker u_checker (.*);

`default_nettype wire
